// ----- rtl/core/mclm_pkg.sv -----
// ----------------------------------------------------------------------------
// mclm_pkg
// Codes and constants shared by the media change latch monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package mclm_pkg;

	// item opcodes
	localparam logic [1:0] OP_OBSERVE = 2'd0;
	localparam logic [1:0] OP_LINK    = 2'd1;
	localparam logic [1:0] OP_FAULT   = 2'd2;

	// media event codes of an observation
	localparam logic [2:0] ME_EJECT   = 3'd1;
	localparam logic [2:0] ME_NEW     = 3'd2;
	localparam logic [2:0] ME_REMOVAL = 3'd3;
	localparam logic [2:0] ME_CHANGED = 3'd4;

	// readiness codes
	localparam logic [1:0] RD_PRESENT = 2'd1;
	localparam logic [1:0] RD_ABSENT  = 2'd2;

	// latched event codes
	localparam logic [2:0] EV_NONE         = 3'd0;
	localparam logic [2:0] EV_EJECT        = 3'd1;
	localparam logic [2:0] EV_CHANGED      = 3'd2;
	localparam logic [2:0] EV_FAULT        = 3'd3;
	localparam logic [2:0] EV_DISCONNECTED = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_ABSENT_CONFIRM     = 2'd0;
	localparam logic [1:0] REG_FAULT_CONFIRM      = 2'd1;
	localparam logic [1:0] REG_DISCONNECT_CONFIRM = 2'd2;

	localparam logic [7:0] CONFIRM_RESET = 8'd3;

	typedef logic [7:0] count_t;

endpackage

`default_nettype wire

// ----- rtl/core/media_change_latch_monitor.sv -----
// ----------------------------------------------------------------------------
// media_change_latch_monitor
// Tracks media, link and session-fault reports and latches the first
// terminal event; every report returns the event latched so far.
// ----------------------------------------------------------------------------
// throughput: one report per cycle while the result channel does not stall;
// the monitor state updates as the report moves from the input register to
// the result register
// reset: no event latched, counters and generation cleared, all three
// confirm thresholds set to 3
`default_nettype none

module media_change_latch_monitor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	// report channel
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [2:0]  media_event,
	input  wire logic [63:0] media_generation,
	input  wire logic [1:0]  readiness,
	input  wire logic        link_known,
	input  wire logic        link_connected,
	// result channel
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [2:0]       latched_event
);

	// configuration registers
	mclm_pkg::count_t absent_confirm_q;
	mclm_pkg::count_t fault_confirm_q;
	mclm_pkg::count_t disconnect_confirm_q;

	// input register
	logic        valid_s1;
	logic [1:0]  opcode_s1;
	logic [2:0]  media_event_s1;
	logic [63:0] media_generation_s1;
	logic [1:0]  readiness_s1;
	logic        link_known_s1;
	logic        link_connected_s1;

	// monitor state
	logic [2:0]       held_q,       held_d;
	logic [63:0]      known_gen_q,  known_gen_d;
	logic             gen_valid_q,  gen_valid_d;
	logic             fault_pend_q, fault_pend_d;
	mclm_pkg::count_t fault_cnt_q,  fault_cnt_d;
	mclm_pkg::count_t absent_cnt_q, absent_cnt_d;
	mclm_pkg::count_t disc_cnt_q,   disc_cnt_d;

	logic             result_valid_q;
	logic [2:0]       latched_event_q;

	logic             advance;
	logic             accept;
	mclm_pkg::count_t fault_inc;
	mclm_pkg::count_t absent_inc;
	mclm_pkg::count_t disc_inc;
	logic             gen_mismatch;
	logic             change_report;

	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	assign result_valid  = result_valid_q;
	assign latched_event = latched_event_q;

	// saturating increments
	assign fault_inc  = (fault_cnt_q < fault_confirm_q) ? fault_cnt_q + 8'd1 : fault_cnt_q;
	assign absent_inc = (absent_cnt_q < absent_confirm_q) ? absent_cnt_q + 8'd1 : absent_cnt_q;
	assign disc_inc   = (disc_cnt_q < disconnect_confirm_q) ? disc_cnt_q + 8'd1 : disc_cnt_q;

	assign gen_mismatch  = media_generation_s1 != known_gen_q;
	assign change_report = media_event_s1 == mclm_pkg::ME_NEW
		|| media_event_s1 == mclm_pkg::ME_REMOVAL
		|| media_event_s1 == mclm_pkg::ME_CHANGED;

	always_comb begin
		held_d       = held_q;
		known_gen_d  = known_gen_q;
		gen_valid_d  = gen_valid_q;
		fault_pend_d = fault_pend_q;
		fault_cnt_d  = fault_cnt_q;
		absent_cnt_d = absent_cnt_q;
		disc_cnt_d   = disc_cnt_q;
		if (held_q == mclm_pkg::EV_NONE) begin
			case (opcode_s1)
				mclm_pkg::OP_OBSERVE: begin
					if (media_event_s1 == mclm_pkg::ME_EJECT) begin
						held_d = mclm_pkg::EV_EJECT;
					end else if (gen_valid_q && (gen_mismatch || change_report)) begin
						held_d = mclm_pkg::EV_CHANGED;
					end else begin
						if (!gen_valid_q) begin
							known_gen_d = media_generation_s1;
							gen_valid_d = 1'b1;
						end
						if (fault_pend_q && readiness_s1 == mclm_pkg::RD_PRESENT) begin
							held_d = mclm_pkg::EV_FAULT;
						end else if (fault_pend_q && fault_inc >= fault_confirm_q) begin
							fault_cnt_d = fault_inc;
							held_d      = mclm_pkg::EV_FAULT;
						end else begin
							fault_cnt_d = fault_pend_q ? fault_inc : 8'd0;
							if (readiness_s1 == mclm_pkg::RD_PRESENT) begin
								absent_cnt_d = 8'd0;
							end else if (readiness_s1 == mclm_pkg::RD_ABSENT) begin
								absent_cnt_d = absent_inc;
								if (absent_inc >= absent_confirm_q) begin
									held_d = mclm_pkg::EV_CHANGED;
								end
							end
						end
					end
				end
				mclm_pkg::OP_LINK: begin
					if (link_known_s1) begin
						if (link_connected_s1) begin
							disc_cnt_d = 8'd0;
						end else begin
							disc_cnt_d = disc_inc;
							if (disc_inc >= disconnect_confirm_q) begin
								held_d = mclm_pkg::EV_DISCONNECTED;
							end
						end
					end
				end
				mclm_pkg::OP_FAULT: begin
					fault_pend_d = 1'b1;
				end
				default: begin
					// unused opcode leaves the state alone
				end
			endcase
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			absent_confirm_q     <= mclm_pkg::CONFIRM_RESET;
			fault_confirm_q      <= mclm_pkg::CONFIRM_RESET;
			disconnect_confirm_q <= mclm_pkg::CONFIRM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mclm_pkg::REG_ABSENT_CONFIRM:     absent_confirm_q     <= cfg_data;
				mclm_pkg::REG_FAULT_CONFIRM:      fault_confirm_q      <= cfg_data;
				mclm_pkg::REG_DISCONNECT_CONFIRM: disconnect_confirm_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1           <= opcode;
			media_event_s1      <= media_event;
			media_generation_s1 <= media_generation;
			readiness_s1        <= readiness;
			link_known_s1       <= link_known;
			link_connected_s1   <= link_connected;
		end
	end

	// state update and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q         <= mclm_pkg::EV_NONE;
			known_gen_q    <= 64'd0;
			gen_valid_q    <= 1'b0;
			fault_pend_q   <= 1'b0;
			fault_cnt_q    <= 8'd0;
			absent_cnt_q   <= 8'd0;
			disc_cnt_q     <= 8'd0;
			result_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				held_q         <= held_d;
				known_gen_q    <= known_gen_d;
				gen_valid_q    <= gen_valid_d;
				fault_pend_q   <= fault_pend_d;
				fault_cnt_q    <= fault_cnt_d;
				absent_cnt_q   <= absent_cnt_d;
				disc_cnt_q     <= disc_cnt_d;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			latched_event_q <= held_d;
		end
	end

	// a latched event never changes until reset
	a_held_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		held_q != mclm_pkg::EV_NONE |=> $stable(held_q))
		else $error("latched event changed after latching");

	// the result taken in matches the monitor state it came from
	a_result_matches: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> latched_event_q == held_q)
		else $error("result does not match held event");

	// the input side only stalls behind a held report
	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && result_valid_q)
		else $error("input stalled with no pending report");

endmodule

`default_nettype wire
